>>> sv/lrp_pkg.sv
// Package for the LR parser core: item kinds, action and event codes,
// and the command word carried from the front to the back part. No dependencies.
package lrp_pkg;

  localparam logic [2:0] KIND_TOKEN   = 3'd0;
  localparam logic [2:0] KIND_LD_ACT  = 3'd1;
  localparam logic [2:0] KIND_LD_GOTO = 3'd2;
  localparam logic [2:0] KIND_LD_RULE = 3'd3;
  localparam logic [2:0] KIND_RESTART = 3'd4;

  localparam logic [1:0] ACT_ERROR  = 2'd0;
  localparam logic [1:0] ACT_SHIFT  = 2'd1;
  localparam logic [1:0] ACT_REDUCE = 2'd2;
  localparam logic [1:0] ACT_ACCEPT = 2'd3;

  localparam logic [1:0] EV_REDUCE = 2'd0;
  localparam logic [1:0] EV_SHIFT  = 2'd1;
  localparam logic [1:0] EV_ACCEPT = 2'd2;
  localparam logic [1:0] EV_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_ACT   = 3'd1;
  localparam logic [2:0] ERR_GOTO  = 3'd2;
  localparam logic [2:0] ERR_STACK = 3'd3;
  localparam logic [2:0] ERR_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    CMD_TOKEN, CMD_LD_ACT, CMD_LD_GOTO, CMD_LD_RULE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic       restart;
    logic [4:0] terminal;
    logic [5:0] row;
    logic [4:0] col;
    logic [1:0] etype;
    logic [5:0] evalue;
    logic [3:0] lhs;
    logic [3:0] len;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_ACT_RD, ST_ACT_EV, ST_RULE_RD, ST_BELOW_RD,
    ST_GOTO_RD, ST_GOTO_EV, ST_EMIT
  } bk_state_t;

endpackage

>>> sv/lrp_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/lrp_front.sv
// Front part: accepts input items, classifies them and feeds a short queue.
// Depends on lrp_pkg.
module lrp_front #(
  parameter int QDEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  logic [4:0]    in_terminal,
  input  logic [5:0]    in_table_row,
  input  logic [4:0]    in_table_col,
  input  logic [1:0]    in_entry_type,
  input  logic [5:0]    in_entry_value,
  input  logic [3:0]    in_rule_lhs,
  input  logic [3:0]    in_rule_length,
  output logic          q_valid,
  input  logic          q_pop,
  output lrp_pkg::cmd_t q_cmd
);
  import lrp_pkg::*;
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t           q_r [QDEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           keep, push;
  cmd_t           c;

  assign in_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = q_r[rp_r];

  // Classify: drop unknown kinds, fold restart into a token-less command.
  always_comb begin
    c = '0;
    c.terminal = in_terminal;
    c.row      = in_table_row;
    c.col      = in_table_col;
    c.etype    = in_entry_type;
    c.evalue   = in_entry_value;
    c.lhs      = in_rule_lhs;
    c.len      = in_rule_length;
    keep       = 1'b1;
    case (in_kind)
      KIND_TOKEN:   c.op = CMD_TOKEN;
      KIND_LD_ACT:  c.op = CMD_LD_ACT;
      KIND_LD_GOTO: c.op = CMD_LD_GOTO;
      KIND_LD_RULE: c.op = CMD_LD_RULE;
      KIND_RESTART: begin
        c.op = CMD_LD_ACT;
        c.restart = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_valid && in_ready && keep;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wp_r] <= c;
    end
  end
endmodule

>>> sv/lrp_back.sv
// Back part: carries out loads and drives the shift-reduce sequence for tokens.
// Depends on lrp_pkg and lrp_ram.
module lrp_back #(
  parameter int MAX_STATES       = 64,
  parameter int MAX_TERMINALS    = 32,
  parameter int MAX_NONTERMINALS = 16,
  parameter int MAX_RULES        = 64,
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_REDUCTIONS   = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  lrp_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_event_res,
  output logic [5:0]    out_rule,
  output logic [5:0]    out_new_state,
  output logic [6:0]    out_stack_depth,
  output logic [2:0]    out_error_code,
  output logic          out_last
);
  import lrp_pkg::*;

  localparam int SW  = $clog2(MAX_STATES);
  localparam int TW  = $clog2(MAX_TERMINALS);
  localparam int NW  = (MAX_NONTERMINALS > 1) ? $clog2(MAX_NONTERMINALS) : 1;
  localparam int RW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int PW  = $clog2(STACK_DEPTH);
  localparam int AAW = SW + TW;
  localparam int GAW = SW + NW;
  localparam int ADEP = MAX_STATES * MAX_TERMINALS;
  localparam int GDEP = MAX_STATES * MAX_NONTERMINALS;
  localparam int CW  = (AAW > GAW) ? AAW : GAW;
  localparam int KW  = $clog2(MAX_REDUCTIONS + 1);

  bk_state_t st_r, st_nxt;

  logic [CW-1:0]  clr_r;
  logic [PW:0]    sp_r;
  logic           done_r;
  logic [KW-1:0]  reds_r;
  logic [5:0]     top_r;     // mirror of the stack top
  logic [5:0]     val_r;
  logic [3:0]     len_r;

  // Result register
  logic [1:0] ev_r;
  logic [5:0] rule_r;
  logic [2:0] code_r;
  logic       last_r;
  logic       ov_r;

  // Memories
  logic           a_we, g_we, r_we, s_we;
  logic [AAW-1:0] a_wa, a_ra;
  logic [7:0]     a_wd, a_rd;
  logic [GAW-1:0] g_wa, g_ra;
  logic [6:0]     g_wd, g_rd;
  logic [RW-1:0]  r_wa, r_ra;
  logic [7:0]     r_wd, r_rd;
  logic [PW-1:0]  s_wa, s_ra;
  logic [5:0]     s_wd, s_rd;

  lrp_ram #(.WIDTH(8), .DEPTH(ADEP)) u_act (
    .clk, .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(a_ra), .rdata(a_rd));
  lrp_ram #(.WIDTH(7), .DEPTH(GDEP)) u_goto (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  lrp_ram #(.WIDTH(8), .DEPTH(MAX_RULES)) u_rule (
    .clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  lrp_ram #(.WIDTH(6), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  // Decoded lookups
  logic        top_ok, term_ok, row_ok_a, row_ok_g, col_ok_a, col_ok_g;
  logic        rule_ok, lhs_ok, below_ok;
  logic [1:0]  a_typ;
  logic [5:0]  a_val;
  logic [PW:0] sp_after;

  assign top_ok   = ({4'd0, top_r} < 10'(MAX_STATES));
  assign term_ok  = ({4'd0, q_cmd.terminal} < 9'(MAX_TERMINALS));
  assign row_ok_a = ({4'd0, q_cmd.row} < 10'(MAX_STATES));
  assign col_ok_a = ({4'd0, q_cmd.col} < 9'(MAX_TERMINALS));
  assign row_ok_g = ({4'd0, q_cmd.row} < 10'(MAX_STATES));
  assign col_ok_g = ({4'd0, q_cmd.col} < 9'(MAX_NONTERMINALS));
  assign rule_ok  = ({5'd0, a_val} < 11'(MAX_RULES));
  assign lhs_ok   = ({5'd0, r_rd[7:4]} < 9'(MAX_NONTERMINALS));
  assign below_ok = ({4'd0, s_rd} < 10'(MAX_STATES));
  assign a_typ    = (top_ok && term_ok) ? a_rd[7:6] : ACT_ERROR;
  assign a_val    = a_rd[5:0];
  assign sp_after = sp_r - (PW+1)'(len_r);

  assign out_valid       = ov_r;
  assign out_event_res   = ev_r;
  assign out_rule        = rule_r;
  assign out_new_state   = top_r;
  assign out_stack_depth = 7'(sp_r);
  assign out_error_code  = code_r;
  assign out_last        = last_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: if (clr_r == CW'(((ADEP > GDEP) ? ADEP : GDEP) - 1)) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid && !ov_r && q_cmd.op == CMD_TOKEN && !q_cmd.restart) begin
          st_nxt = done_r ? ST_EMIT : ST_ACT_RD;
        end
      end
      // hold while the previous result still waits
      ST_ACT_RD: if (!ov_r) st_nxt = ST_ACT_EV;
      ST_ACT_EV: begin
        if (a_typ == ACT_REDUCE && reds_r < KW'(MAX_REDUCTIONS) && rule_ok) begin
          st_nxt = ST_RULE_RD;
        end else begin
          st_nxt = ST_EMIT;
        end
      end
      ST_RULE_RD: st_nxt = ((PW+1)'(r_rd[3:0]) >= sp_r) ? ST_EMIT : ST_BELOW_RD;
      ST_BELOW_RD: st_nxt = (!lhs_ok || !below_ok) ? ST_EMIT : ST_GOTO_RD;
      ST_GOTO_RD: st_nxt = ST_GOTO_EV;
      ST_GOTO_EV: st_nxt = ST_EMIT;
      ST_EMIT: if (!ov_r) st_nxt = last_r ? ST_IDLE : ST_ACT_RD;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Memory ports and pop
  always_comb begin
    a_we = 1'b0;
    a_wd = {q_cmd.etype, q_cmd.evalue};
    g_we = 1'b0; g_wa = '0; g_wd = {1'b1, q_cmd.evalue};
    r_we = 1'b0; r_wa = RW'(q_cmd.row); r_wd = {q_cmd.lhs, q_cmd.len};
    s_we = 1'b0; s_wa = PW'(sp_r); s_wd = val_r;
    a_ra = AAW'({SW'(top_r), q_cmd.terminal[TW-1:0]});
    a_wa = AAW'({SW'(q_cmd.row), q_cmd.col[TW-1:0]});
    g_ra = GAW'({SW'(s_rd), NW'(r_rd[7:4])});
    r_ra = RW'(val_r);
    s_ra = PW'(sp_r - (PW+1)'(1) - (PW+1)'(r_rd[3:0]));
    q_pop = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        a_we = 1'b1; a_wa = AAW'(clr_r); a_wd = '0;
        g_we = 1'b1; g_wa = GAW'(clr_r); g_wd = '0;
        s_we = 1'b1; s_wa = '0; s_wd = '0;
      end
      ST_IDLE: begin
        if (q_valid && !ov_r) begin
          case (q_cmd.op)
            CMD_LD_ACT:  begin a_we = !q_cmd.restart && row_ok_a && col_ok_a; q_pop = 1'b1; end
            CMD_LD_GOTO: begin
              g_we = row_ok_g && col_ok_g;
              g_wa = GAW'({SW'(q_cmd.row), NW'(q_cmd.col)});
              q_pop = 1'b1;
            end
            CMD_LD_RULE: begin r_we = ({5'd0, q_cmd.row} < 11'(MAX_RULES)); q_pop = 1'b1; end
            CMD_TOKEN:   q_pop = 1'b0;
            default:     q_pop = 1'b1;
          endcase
          if (q_cmd.restart) begin
            s_we = 1'b1; s_wa = '0; s_wd = '0;
          end
        end
      end
      ST_GOTO_EV: begin
        s_we = g_rd[6] && (sp_after < (PW+1)'(STACK_DEPTH));
        s_wa = PW'(sp_after); s_wd = g_rd[5:0];
      end
      ST_ACT_EV: begin
        s_we = (a_typ == ACT_SHIFT) && (sp_r < (PW+1)'(STACK_DEPTH));
        s_wa = PW'(sp_r); s_wd = a_val;
        // fetch the rule named by the action now, so it lands for the rule read
        r_ra = RW'(a_val);
      end
      ST_EMIT: q_pop = !ov_r && last_r;
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLEAR;
      clr_r  <= '0;
      sp_r   <= (PW+1)'(1);
      done_r <= 1'b0;
      top_r  <= '0;
      ov_r   <= 1'b0;
      reds_r <= '0;
      last_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          reds_r <= '0;
          if (q_valid && !ov_r && q_cmd.restart) begin
            sp_r <= (PW+1)'(1); top_r <= '0; done_r <= 1'b0;
          end
          if (q_valid && !ov_r && q_cmd.op == CMD_TOKEN && !q_cmd.restart && done_r) begin
            ev_r <= EV_ERROR; code_r <= ERR_ACT; rule_r <= '0; last_r <= 1'b1;
          end
        end
        ST_ACT_EV: begin
          val_r <= a_val; rule_r <= '0; last_r <= 1'b1; code_r <= ERR_NONE;
          case (a_typ)
            ACT_SHIFT: begin
              if (sp_r < (PW+1)'(STACK_DEPTH)) begin
                ev_r <= EV_SHIFT; sp_r <= sp_r + 1'b1; top_r <= a_val;
              end else begin
                ev_r <= EV_ERROR; code_r <= ERR_STACK; done_r <= 1'b1;
              end
            end
            ACT_ACCEPT: begin ev_r <= EV_ACCEPT; done_r <= 1'b1; end
            ACT_REDUCE: begin
              if (reds_r >= KW'(MAX_REDUCTIONS)) begin
                ev_r <= EV_ERROR; code_r <= ERR_LIMIT; done_r <= 1'b1;
              end else if (!rule_ok) begin
                ev_r <= EV_ERROR; code_r <= ERR_ACT; done_r <= 1'b1;
              end
            end
            default: begin ev_r <= EV_ERROR; code_r <= ERR_ACT; done_r <= 1'b1; end
          endcase
        end
        ST_RULE_RD: begin
          len_r <= r_rd[3:0];
          if ((PW+1)'(r_rd[3:0]) >= sp_r) begin
            ev_r <= EV_ERROR; code_r <= ERR_STACK; done_r <= 1'b1;
          end
        end
        ST_BELOW_RD: begin
          if (!lhs_ok || !below_ok) begin
            ev_r <= EV_ERROR; code_r <= ERR_GOTO; done_r <= 1'b1;
          end
        end
        ST_GOTO_EV: begin
          if (!g_rd[6]) begin
            ev_r <= EV_ERROR; code_r <= ERR_GOTO; done_r <= 1'b1;
          end else if (sp_after >= (PW+1)'(STACK_DEPTH)) begin
            ev_r <= EV_ERROR; code_r <= ERR_STACK; done_r <= 1'b1;
          end else begin
            ev_r <= EV_REDUCE; rule_r <= val_r; last_r <= 1'b0;
            sp_r <= sp_after + 1'b1; top_r <= g_rd[5:0];
            reds_r <= reds_r + 1'b1;
          end
        end
        ST_EMIT: if (!ov_r) ov_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

>>> sv/lr_table_driven_parser_unit.sv
// LR(1) shift-reduce parser core: top level joining front queue and back sequencer.
// Depends on lrp_pkg, lrp_front, lrp_back and lrp_ram.
//
// After reset the action and goto tables are swept to error and invalid, one
// entry a cycle, together with stack entry zero; up to two requests queue up
// meanwhile but are held until the sweep ends. The back sequencer carries out a
// load or restart item directly from its idle state. A token passes through
// dispatch, action read and action decode to its emit, and each reduction adds
// action read and decode, rule, stack and goto reads through registered memories,
// goto update and emit. While a result waits for out_ready the sequencer holds
// before its next action lookup and takes no queued request; the front queue
// holds two items, so input stays open until it fills. Each request on the output
// carries one event; last marks the final one of a token.
module lr_table_driven_parser_unit #(
  parameter int MAX_STATES       = 64,
  parameter int MAX_TERMINALS    = 32,
  parameter int MAX_NONTERMINALS = 16,
  parameter int MAX_RULES        = 64,
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_REDUCTIONS   = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_kind,
  input  logic [4:0] in_terminal,
  input  logic [5:0] in_table_row,
  input  logic [4:0] in_table_col,
  input  logic [1:0] in_entry_type,
  input  logic [5:0] in_entry_value,
  input  logic [3:0] in_rule_lhs,
  input  logic [3:0] in_rule_length,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_res,
  output logic [5:0] out_rule,
  output logic [5:0] out_new_state,
  output logic [6:0] out_stack_depth,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import lrp_pkg::*;

  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Queue of classified requests
  lrp_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_terminal, .in_table_row,
    .in_table_col, .in_entry_type, .in_entry_value, .in_rule_lhs, .in_rule_length,
    .q_valid, .q_pop, .q_cmd);

  // Table memories, state stack and shift-reduce sequencer
  lrp_back #(
    .MAX_STATES(MAX_STATES), .MAX_TERMINALS(MAX_TERMINALS),
    .MAX_NONTERMINALS(MAX_NONTERMINALS), .MAX_RULES(MAX_RULES),
    .STACK_DEPTH(STACK_DEPTH), .MAX_REDUCTIONS(MAX_REDUCTIONS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd, .out_valid, .out_ready,
    .out_event_res, .out_rule, .out_new_state, .out_stack_depth,
    .out_error_code, .out_last);

  // A reduce never closes a token; errors carry a code and a zero rule; depth is never zero.
  a_reduce_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_REDUCE |-> !out_last)
    else $error("reduce flagged last");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ERROR |-> out_error_code != ERR_NONE && out_rule == 6'd0)
    else $error("error result without code");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stack_depth != 7'd0)
    else $error("empty stack reported");
endmodule
